@@ sv/wsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PROTO   = 2'd1,
    ST_TOO_BIG = 2'd2,
    ST_ABORTED = 2'd3
  } status_t;

  // one result record as produced by the parser, unmasking still to do
  typedef struct packed {
    status_t    status;
    logic [3:0] opcode;
    logic       fin;
    logic [7:0] raw;
    logic [7:0] key;
    logic       valid;
    logic       last;
  } wsd_res_t;

  localparam logic [63:0] MAX_PAYLOAD_RST = 64'd16777216;

  localparam logic [7:0] HDR_FIN  = 8'h80;
  localparam logic [7:0] HDR_RSV  = 8'h70;
  localparam logic [7:0] HDR_MASK = 8'h80;
  localparam logic [3:0] OP_RSV_LO  = 4'h3;
  localparam logic [3:0] OP_RSV_HI  = 4'h7;
  localparam logic [3:0] OP_RSV_CTL = 4'hB;
  localparam logic [3:0] OP_CTRL    = 4'h8;
  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  // configuration register index, taken from the register select bit of paddr
  localparam logic REG_MAX_PAYLOAD = 1'b0;

endpackage

`default_nettype wire

@@ sv/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            contents
// s_*       in   s_tvalid/s_tready    raw byte or abort
// m_*       out  m_tvalid/m_tready    result beat, one per payload byte or event
// apb       in   psel/penable/pready  max_payload at byte address 0
//
// one byte is taken each cycle while the result queue has room; the parser
// updates its state in the cycle the beat is accepted, and a result reaches m_*
// through the queue and then the output register.
// s_tready drops only when the result queue is full, so m_tready stalls reach
// the input after QUEUE_DEPTH + 1 pending results.
// rst is synchronous; it restores the parser to the first header byte and
// max_payload to 16 MiB.

module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // stream_byte
  input  wire logic [0:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // frame_opcode, frame_fin, payload_byte
  output logic [2:0]       m_tuser,   // status, byte_valid
  output logic             m_tlast,   // last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] max_payload;
  logic        in_fire;
  logic        push;
  wsd_res_t    push_data;
  logic        full;
  logic        pop;
  logic        head_valid;
  wsd_res_t    head_data;

  assign pready   = 1'b1;
  assign s_tready = !full;
  assign in_fire  = s_tvalid && s_tready;
  assign prdata   = (paddr[3] == REG_MAX_PAYLOAD) ? max_payload : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready && paddr[3] == REG_MAX_PAYLOAD) begin
      max_payload <= pwdata;
    end
  end

  wsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .func        (s_tuser[0]),
    .stream_byte (s_tdata),
    .max_payload (max_payload),
    .push        (push),
    .res         (push_data)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  wsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

@@ sv/wsd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wsd_front
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_fire,
  input  wire logic        func,
  input  wire logic [7:0]  stream_byte,
  input  wire logic [63:0] max_payload,
  output logic             push,
  output wsd_res_t         res
);

  typedef enum logic [6:0] {
    PH_HDR0    = 7'b0000001,
    PH_HDR1    = 7'b0000010,
    PH_EXT16   = 7'b0000100,
    PH_EXT64   = 7'b0001000,
    PH_MASK    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DISCARD = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  first_header, first_header_next;
  logic [2:0]  byte_counter, byte_counter_next;
  logic [63:0] length_left, length_left_next;
  logic [31:0] mask_word, mask_word_next;
  logic [1:0]  mask_index, mask_index_next;

  logic [3:0]  op;
  logic [6:0]  len7;
  logic [2:0]  cnt_inc;
  logic [63:0] len_shift;
  logic [63:0] len_full;
  logic        too_big;
  logic        bad;
  logic        do_restart;

  assign op        = first_header[3:0];
  assign len7      = stream_byte[6:0];
  assign cnt_inc   = byte_counter + 3'd1;
  assign len_shift = {length_left[55:0], stream_byte};
  assign len_full  = (phase == PH_HDR1) ? {57'd0, len7} : len_shift;
  assign too_big   = len_full > max_payload;

  always_comb begin
    bad = 1'b0;
    if ((first_header & HDR_RSV) != 8'd0) begin
      bad = 1'b1;
    end else if ((op >= OP_RSV_LO && op <= OP_RSV_HI) || op >= OP_RSV_CTL) begin
      bad = 1'b1;
    end else if ((stream_byte & HDR_MASK) == 8'd0) begin
      bad = 1'b1;
    end else if (op >= OP_CTRL &&
                 ((first_header & HDR_FIN) == 8'd0 || len7 > LEN_CTRL_MAX)) begin
      bad = 1'b1;
    end
  end

  always_comb begin
    phase_next        = phase;
    first_header_next = first_header;
    byte_counter_next = byte_counter;
    length_left_next  = length_left;
    mask_word_next    = mask_word;
    mask_index_next   = mask_index;
    do_restart        = 1'b0;
    push              = 1'b0;
    res.status        = ST_OK;
    res.opcode        = first_header[3:0];
    res.fin           = first_header[7];
    res.raw           = 8'd0;
    res.key           = 8'd0;
    res.valid         = 1'b0;
    res.last          = 1'b1;

    if (in_fire) begin
      if (func) begin
        if (phase != PH_HDR0 && phase != PH_DISCARD) begin
          push       = 1'b1;
          res.status = ST_ABORTED;
        end
        do_restart = 1'b1;
      end else begin
        unique case (phase)
          PH_HDR0: begin
            first_header_next = stream_byte;
            phase_next        = PH_HDR1;
          end
          PH_HDR1: begin
            length_left_next  = 64'd0;
            byte_counter_next = 3'd0;
            if (bad) begin
              phase_next = PH_DISCARD;
              push       = 1'b1;
              res.status = ST_PROTO;
            end else if (len7 == LEN_EXT16) begin
              phase_next = PH_EXT16;
            end else if (len7 == LEN_EXT64) begin
              phase_next = PH_EXT64;
            end else begin
              length_left_next = {57'd0, len7};
              if (too_big) begin
                phase_next = PH_DISCARD;
                push       = 1'b1;
                res.status = ST_TOO_BIG;
              end else begin
                phase_next     = PH_MASK;
                mask_word_next = 32'd0;
              end
            end
          end
          PH_EXT16, PH_EXT64: begin
            length_left_next  = len_shift;
            byte_counter_next = cnt_inc;
            if ((phase == PH_EXT16 && cnt_inc == 3'd2) ||
                (phase == PH_EXT64 && cnt_inc == 3'd0)) begin
              byte_counter_next = 3'd0;
              if (too_big) begin
                phase_next = PH_DISCARD;
                push       = 1'b1;
                res.status = ST_TOO_BIG;
              end else begin
                phase_next     = PH_MASK;
                mask_word_next = 32'd0;
              end
            end
          end
          PH_MASK: begin
            mask_word_next[8*byte_counter[1:0] +: 8] = stream_byte;
            byte_counter_next = cnt_inc;
            if (cnt_inc == 3'd4) begin
              byte_counter_next = 3'd0;
              mask_index_next   = 2'd0;
              if (length_left == 64'd0) begin
                push       = 1'b1;
                do_restart = 1'b1;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            push             = 1'b1;
            res.raw          = stream_byte;
            res.key          = mask_word[8*mask_index +: 8];
            res.valid        = 1'b1;
            res.last         = (length_left == 64'd1);
            mask_index_next  = mask_index + 2'd1;
            length_left_next = length_left - 64'd1;
            if (length_left == 64'd1) begin
              do_restart = 1'b1;
            end
          end
          PH_DISCARD: begin
          end
          default: begin
            do_restart = 1'b1;
          end
        endcase
      end
    end

    if (do_restart) begin
      phase_next        = PH_HDR0;
      first_header_next = 8'd0;
      byte_counter_next = 3'd0;
      length_left_next  = 64'd0;
      mask_word_next    = 32'd0;
      mask_index_next   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      first_header <= 8'd0;
      byte_counter <= 3'd0;
      length_left  <= 64'd0;
      mask_word    <= 32'd0;
      mask_index   <= 2'd0;
    end else begin
      phase        <= phase_next;
      first_header <= first_header_next;
      byte_counter <= byte_counter_next;
      length_left  <= length_left_next;
      mask_word    <= mask_word_next;
      mask_index   <= mask_index_next;
    end
  end

`ifndef SYNTH
  a_data_only_ok: assert property (@(posedge clk) disable iff (rst)
    (push && res.valid) |-> (res.status == ST_OK))
    else $error("payload beat carries an error status");

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !func && phase == PH_DISCARD) |-> !push)
    else $error("result produced while discarding");

  a_payload_has_length: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (length_left != 64'd0))
    else $error("payload phase with no length left");
`endif

endmodule

`default_nettype wire

@@ sv/wsd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue
  import wsd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire wsd_res_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output wsd_res_t      head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsd_res_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

@@ sv/wsd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wsd_back
  import wsd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         head_valid,
  input  wire wsd_res_t     head_data,
  output logic              pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [15:0]       m_tdata,
  output logic [2:0]        m_tuser,
  output logic              m_tlast
);

  logic [7:0] unmasked;

  assign pop      = head_valid && (!m_tvalid || m_tready);
  assign unmasked = head_data.raw ^ head_data.key;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {3'd0, unmasked, head_data.fin, head_data.opcode};
      m_tuser <= {head_data.valid, head_data.status};
      m_tlast <= head_data.last;
    end
  end

endmodule

`default_nettype wire
